// ----- hdl/lssr_pkg.sv -----
// Package: shared types, constants and helpers for the light screen rectangle block.
package lssr_pkg;

  localparam int unsigned CornerCount = 8;
  localparam int unsigned CfgRegCount = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned ScrW        = 17;
  localparam int unsigned ClipW       = 66;   // three 48-bit terms plus a 32-bit entry
  localparam int unsigned QuotW       = 15;   // quotient bits of c*32768/w below 32768
  localparam logic [ScrW-1:0] ScrOne  = 17'd65536;
  localparam logic [ScrW-1:0] ScrHalf = 17'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    RegM00M01 = 3'd0,
    RegM02M03 = 3'd1,
    RegM10M11 = 3'd2,
    RegM12M13 = 3'd3,
    RegM20M21 = 3'd4,
    RegM22M23 = 3'd5,
    RegM30M31 = 3'd6,
    RegM32M33 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic        [30:0] light_range;
  } light_t;

  typedef struct packed {
    logic [ScrW-1:0] rect_min_x;
    logic [ScrW-1:0] rect_min_y;
    logic [ScrW-1:0] rect_max_x;
    logic [ScrW-1:0] rect_max_y;
    logic            behind_eye;
  } rect_t;

  // One corner in clip space, handed from the transform front to the divide back.
  typedef struct packed {
    logic signed [ClipW-1:0] cx;
    logic signed [ClipW-1:0] cy;
    logic signed [ClipW-1:0] cw;
    logic                    last;
  } corner_t;

  // Saturate a 33-bit sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hdl/lssr_front.sv -----
// Front: walks the eight cube corners of an item and transforms each into clip space.
module lssr_front import lssr_pkg::*; #(
  parameter int unsigned CORNER_COUNT = CornerCount
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  light_t                   item_i,
  input  logic [CfgRegCount-1:0][CfgDataW-1:0] vp_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output corner_t                  out_o
);

  localparam int unsigned KW = $clog2(CORNER_COUNT);

  // Stage 0: corner generation; stage 1: products; stage 2: row sums.
  logic           busy_q, busy_d;
  logic [KW-1:0]  k_q, k_d;
  light_t         item_q;
  logic           v1_q, v2_q;
  logic           last1_q;
  logic signed [47:0] p_q [3][3];   // [row x,y,w][axis]
  logic signed [31:0] e3_q [3];
  corner_t        c2_q;
  logic           adv;

  assign adv   = !v2_q || out_ready_i;
  assign full_o = busy_q;

  logic signed [31:0] v [3];
  logic signed [31:0] lc [3];
  logic signed [32:0] rng;

  always_comb begin
    lc[0] = item_q.light_x;
    lc[1] = item_q.light_y;
    lc[2] = item_q.light_z;
    rng   = $signed({2'b00, item_q.light_range});
    for (int a = 0; a < 3; a++) begin
      if (k_q[2-a]) v[a] = sat32($signed({lc[a][31], lc[a]}) + rng);
      else          v[a] = sat32($signed({lc[a][31], lc[a]}) - rng);
    end
  end

  function automatic logic signed [31:0] ent(input logic [CfgRegCount-1:0][CfgDataW-1:0] m,
                                             input int r, input int c);
    logic [63:0] w;
    w = m[r*2 + c/2];
    return (c % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (busy_q && adv) begin
      k_d = k_q + KW'(1);
      if (k_q == KW'(CORNER_COUNT-1)) begin
        busy_d = 1'b0;
        k_d    = '0;
      end
    end
    if (push_i && !busy_q) busy_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      if (adv) begin
        v1_q <= busy_q;
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !busy_q) item_q <= item_i;
    if (adv) begin
      last1_q <= (k_q == KW'(CORNER_COUNT-1));
      for (int r = 0; r < 3; r++) begin
        e3_q[r] <= ent(vp_i, (r == 2) ? 3 : r, 3);
        for (int a = 0; a < 3; a++) begin
          // exact Q32.32 product, floor-shifted to Q.16
          p_q[r][a] <= 48'($signed(64'(ent(vp_i, (r == 2) ? 3 : r, a)) * 64'(v[a])) >>> 16);
        end
      end
      c2_q.cx   <= ClipW'(p_q[0][0]) + ClipW'(p_q[0][1]) + ClipW'(p_q[0][2]) + ClipW'(e3_q[0]);
      c2_q.cy   <= ClipW'(p_q[1][0]) + ClipW'(p_q[1][1]) + ClipW'(p_q[1][2]) + ClipW'(e3_q[1]);
      c2_q.cw   <= ClipW'(p_q[2][0]) + ClipW'(p_q[2][1]) + ClipW'(p_q[2][2]) + ClipW'(e3_q[2]);
      c2_q.last <= last1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = c2_q;

endmodule

// ----- hdl/lssr_fifo.sv -----
// Short queue of clip-space corners between the front and the back.
module lssr_fifo import lssr_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  output logic    wr_ready_o,
  input  corner_t wr_data_i,
  output logic    rd_valid_o,
  input  logic    rd_ready_i,
  output corner_t rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  corner_t         mem_q [DEPTH];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic            wr, rd;

  assign wr_ready_o = (cnt_q != (AW+1)'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
      if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ----- hdl/lssr_back.sv -----
// Back: divides each corner by w, maps to screen space and folds the rectangle.
module lssr_back import lssr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  corner_t in_i,
  output logic    empty_o,
  input  logic    pop_i,
  output rect_t   rect_o
);

  // Both x and y are divided at once by a restoring divider, one bit a cycle.
  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SDiv  = 3'b010,
    SDone = 3'b100
  } st_e;

  st_e              st_q;
  logic [4:0]       bit_q;
  logic [ClipW-1:0] w_q;
  logic [ClipW-1:0] rx_q, ry_q;           // running remainders
  logic [QuotW-1:0] qx_q, qy_q;
  logic             nx_q, ny_q;           // c negative
  logic [1:0]       sat_x_q, sat_y_q;     // 01: 0, 10: one, 00: divide
  logic             last_q;
  logic [ScrW-1:0]  mnx_q, mny_q, mxx_q, mxy_q;
  logic             beh_q;
  rect_t            out_q;
  logic             out_v_q;

  assign in_ready_o = (st_q == SIdle);
  assign empty_o    = !out_v_q;
  assign rect_o     = out_q;

  function automatic logic [1:0] sat_code(input logic signed [ClipW-1:0] c,
                                          input logic signed [ClipW-1:0] w);
    if (c >= w)       return 2'b10;
    else if (c <= -w) return 2'b01;
    else              return 2'b00;
  endfunction

  function automatic logic [ScrW-1:0] screen(input logic [1:0] s, input logic neg,
                                             input logic [QuotW-1:0] q,
                                             input logic rem_nz);
    logic [ScrW-1:0] qq;
    qq = ScrW'(q) + ScrW'(neg && rem_nz);
    if (s == 2'b10)  return ScrOne;
    if (s == 2'b01)  return '0;
    if (neg)         return ScrHalf - qq;
    return ScrHalf + qq;
  endfunction

  logic [ClipW-1:0] tx, ty;
  logic [ScrW-1:0]  sx, sy;
  logic             can_fold;

  always_comb begin
    tx = {rx_q[ClipW-2:0], 1'b0};
    ty = {ry_q[ClipW-2:0], 1'b0};
    sx = screen(sat_x_q, nx_q, qx_q, rx_q != '0);
    sy = screen(sat_y_q, ny_q, qy_q, ry_q != '0);
  end

  assign can_fold = (st_q == SDone) && (!last_q || !out_v_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      out_v_q <= 1'b0;
      mnx_q   <= ScrOne;
      mny_q   <= ScrOne;
      mxx_q   <= '0;
      mxy_q   <= '0;
      beh_q   <= 1'b0;
      bit_q   <= '0;
    end else begin
      if (pop_i && out_v_q) out_v_q <= 1'b0;
      unique case (st_q)
        SIdle: begin
          if (in_valid_i) begin
            st_q  <= ($signed(in_i.cw) <= 0) ? SDone : SDiv;
            bit_q <= 5'(QuotW - 1);
          end
        end
        SDiv: begin
          bit_q <= bit_q - 5'd1;
          if (bit_q == '0) st_q <= SDone;
        end
        SDone: begin
          if (can_fold) begin
            st_q <= SIdle;
            if (last_q) begin
              out_v_q <= 1'b1;
              mnx_q <= ScrOne;
              mny_q <= ScrOne;
              mxx_q <= '0;
              mxy_q <= '0;
              beh_q <= 1'b0;
            end else if (!beh_q && $signed(w_q) > 0) begin
              if (sx < mnx_q) mnx_q <= sx;
              if (sx > mxx_q) mxx_q <= sx;
              if (sy < mny_q) mny_q <= sy;
              if (sy > mxy_q) mxy_q <= sy;
            end else begin
              beh_q <= 1'b1;
            end
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  logic [ScrW-1:0] fmnx, fmny, fmxx, fmxy;
  logic            fbeh;
  always_comb begin
    fbeh = beh_q || ($signed(w_q) <= 0);
    fmnx = mnx_q; fmny = mny_q; fmxx = mxx_q; fmxy = mxy_q;
    if (!fbeh) begin
      if (sx < fmnx) fmnx = sx;
      if (sx > fmxx) fmxx = sx;
      if (sy < fmny) fmny = sy;
      if (sy > fmxy) fmxy = sy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && in_valid_i) begin
      w_q     <= in_i.cw;
      last_q  <= in_i.last;
      sat_x_q <= sat_code(in_i.cx, in_i.cw);
      sat_y_q <= sat_code(in_i.cy, in_i.cw);
      nx_q    <= in_i.cx[ClipW-1];
      ny_q    <= in_i.cy[ClipW-1];
      rx_q    <= in_i.cx[ClipW-1] ? -in_i.cx : in_i.cx;
      ry_q    <= in_i.cy[ClipW-1] ? -in_i.cy : in_i.cy;
      qx_q    <= '0;
      qy_q    <= '0;
    end else if (st_q == SDiv) begin
      // |c| < w here, so each step keeps the remainder below w.
      if (tx >= w_q) begin rx_q <= tx - w_q; qx_q <= {qx_q[QuotW-2:0], 1'b1}; end
      else begin rx_q <= tx; qx_q <= {qx_q[QuotW-2:0], 1'b0}; end
      if (ty >= w_q) begin ry_q <= ty - w_q; qy_q <= {qy_q[QuotW-2:0], 1'b1}; end
      else begin ry_q <= ty; qy_q <= {qy_q[QuotW-2:0], 1'b0}; end
    end
    if (can_fold && last_q) begin
      out_q.behind_eye <= fbeh;
      out_q.rect_min_x <= fbeh ? '0 : fmnx;
      out_q.rect_min_y <= fbeh ? '0 : fmny;
      out_q.rect_max_x <= fbeh ? ScrOne : fmxx;
      out_q.rect_max_y <= fbeh ? ScrOne : fmxy;
    end
  end

endmodule

// ----- hdl/light_sphere_screen_rect.sv -----
// Top level: light sphere to screen rectangle, front transform, corner queue, divide back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   item in  | push / full          | item_i   (light_t)
//   result   | empty / pop          | rect_o   (rect_t)
//   config   | cfg_valid_i/ready_o  | cfg_idx_i, cfg_data_i (64 bit)
//
// The front emits one clip-space corner per cycle while the queue accepts it, and the
// back's bit-serial divider (15 steps plus load and fold) sets the item rate. Corners
// with w <= 0 skip the divider and go from load straight to fold.
// Reset clears all control state and the matrix registers; no clearing pass.
// A waiting result holds while pop is low; the back then stalls the queue at the next last corner.
module light_sphere_screen_rect import lssr_pkg::*; #(
  parameter int unsigned CORNER_COUNT = CornerCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  light_t              item_i,
  output logic                empty,
  input  logic                pop,
  output rect_t               rect_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgRegCount-1:0][CfgDataW-1:0] vp_q;
  logic    f_valid, f_ready, b_valid, b_ready;
  corner_t f_corner, b_corner;

  // Registers are always writable; software must write them only while idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else if (cfg_valid_i) begin
      vp_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Front: walk corners and transform.
  lssr_front #(.CORNER_COUNT(CORNER_COUNT)) u_front (
    .clk_i, .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .vp_i        (vp_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_o       (f_corner)
  );

  // Queue: decouple transform from divide.
  lssr_fifo #(.DEPTH(4)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_corner),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_corner)
  );

  // Back: divide, map and fold.
  lssr_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (b_valid),
    .in_ready_o (b_ready),
    .in_i       (b_corner),
    .empty_o    (empty),
    .pop_i      (pop),
    .rect_o     (rect_o)
  );

`ifndef NO_ASSERTIONS
  a_full_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rect_o.behind_eye) |-> (rect_o.rect_max_x == ScrOne))
    else $error("behind-eye result is not full screen");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !rect_o.behind_eye) |-> (rect_o.rect_min_x <= ScrOne))
    else $error("rectangle edge out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rect_o)))
    else $error("waiting result changed");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the light sphere screen rectangle block: table-driven and random lights.
module tb_top;
  import lssr_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  light_t              item_i;
  logic                empty;
  logic                pop;
  rect_t               rect_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  light_sphere_screen_rect u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .rect_o     (rect_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainWait  = 400;

  // Matrix copy held by the bench, one 64-bit word per register.
  logic [CfgDataW-1:0] vp_copy [CfgRegCount];
  rect_t               rect_queue [$];

  int unsigned n_cycles;
  int unsigned n_fail;
  int unsigned n_lights;
  int unsigned n_rects;
  int unsigned n_behind;
  int unsigned n_cfg;
  bit          sink_quiet;
  bit          src_quiet;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("light_sphere_screen_rect: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor: matrix entry r,c from the packed register words.
  function automatic logic signed [63:0] vp_entry(int r, int c);
    logic [63:0] w;
    w = vp_copy[r * 2 + c / 2];
    return (c % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
  endfunction

  // Floor-shift right by 16 (arithmetic shift is floor on two's complement).
  function automatic logic signed [63:0] clip_row(int r, logic signed [63:0] v [3]);
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    acc = vp_entry(r, 3);
    for (int c = 0; c < 3; c++) begin
      prod = vp_entry(r, c) * v[c];
      acc  = acc + (prod >>> 16);
    end
    return acc;
  endfunction

  // Map clip coordinate c with w > 0 to Q1.16 screen space, floor rounding.
  function automatic logic [ScrW-1:0] screen_coord(logic signed [63:0] c,
                                                   logic signed [63:0] w);
    logic [127:0] num;
    logic [127:0] q;
    if (c >= w) return ScrOne;
    if (c <= -w) return '0;
    if (c >= 0) begin
      num = 128'(c) * 128'd32768;
      q   = num / 128'(w);
      return ScrW'(32768 + q);
    end
    num = 128'(-c) * 128'd32768 + 128'(w) - 128'd1;
    q   = num / 128'(w);
    return ScrW'(32768 - q);
  endfunction

  function automatic logic signed [63:0] sat_coord(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic rect_t light_rect(light_t it);
    rect_t              r;
    logic signed [63:0] ctr [3];
    logic signed [63:0] v [3];
    logic signed [63:0] rng;
    logic signed [63:0] cx, cy, cw;
    logic [ScrW-1:0]    sx, sy;
    r = '{rect_min_x: ScrOne, rect_min_y: ScrOne, rect_max_x: '0, rect_max_y: '0,
          behind_eye: 1'b0};
    ctr[0] = 64'(it.light_x);
    ctr[1] = 64'(it.light_y);
    ctr[2] = 64'(it.light_z);
    rng    = 64'(it.light_range);
    for (int k = 0; k < CornerCount; k++) begin
      for (int a = 0; a < 3; a++)
        v[a] = sat_coord(((k >> (2 - a)) & 1) ? ctr[a] + rng : ctr[a] - rng);
      cx = clip_row(0, v);
      cy = clip_row(1, v);
      cw = clip_row(3, v);
      if (cw <= 0) begin
        r.behind_eye = 1'b1;
        continue;
      end
      sx = screen_coord(cx, cw);
      sy = screen_coord(cy, cw);
      if (sx < r.rect_min_x) r.rect_min_x = sx;
      if (sx > r.rect_max_x) r.rect_max_x = sx;
      if (sy < r.rect_min_y) r.rect_min_y = sy;
      if (sy > r.rect_max_y) r.rect_max_y = sy;
    end
    if (r.behind_eye) begin
      r.rect_min_x = '0;
      r.rect_min_y = '0;
      r.rect_max_x = ScrOne;
      r.rect_max_y = ScrOne;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pop with random stall bursts, compare against the oldest rect.
  initial begin
    int unsigned burst;
    rect_t       want;
    pop = 1'b0;
    burst = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        n_rects++;
        if (rect_queue.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected rect %h", rect_o);
        end else begin
          want = rect_queue.pop_front();
          if (rect_o !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("rect mismatch: exp min %0d,%0d max %0d,%0d be %0b / got %0d,%0d %0d,%0d %0b",
                       want.rect_min_x, want.rect_min_y, want.rect_max_x, want.rect_max_y,
                       want.behind_eye, rect_o.rect_min_x, rect_o.rect_min_y,
                       rect_o.rect_max_x, rect_o.rect_max_y, rect_o.behind_eye);
          end
        end
      end
      // Stall in bursts; hold pop high when quiet.
      if (burst > 0) begin
        burst--;
        pop <= 1'b0;
      end else if (!sink_quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source side helpers.
  int unsigned gap_left;

  // Leaves push high after the accepting edge; the next gap or pause drops it.
  task automatic send_light(light_t it);
    // Idle in random bursts before offering the item.
    if (!src_quiet && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(1, 19);
      push <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    rect_queue.push_back(light_rect(it));
    n_lights++;
    if (rect_queue[$].behind_eye) n_behind++;
  endtask

  // Wait until the block has drained every rect, then let the divider settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (rect_queue.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    vp_copy[idx] = data;
    n_cfg++;
  endtask

  function automatic logic [31:0] q16(int v);
    return 32'(v) << 16;
  endfunction

  // Load a full matrix: rows given as four Q16.16 entries each.
  task automatic load_matrix(logic [31:0] m [16]);
    for (int r = 0; r < 4; r++) begin
      write_reg(cfg_reg_e'(r * 2),     {m[r * 4 + 1], m[r * 4 + 0]});
      write_reg(cfg_reg_e'(r * 2 + 1), {m[r * 4 + 3], m[r * 4 + 2]});
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic light_t rand_light(int unsigned mode);
    light_t it;
    case (mode)
      0: begin
        // Lights near the origin with small ranges.
        it.light_x     = 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
        it.light_y     = 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
        it.light_z     = 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
        it.light_range = 31'($urandom_range(0, 4 << 16));
      end
      1: begin
        // Full-range noise on every bit.
        it.light_x     = $urandom;
        it.light_y     = $urandom;
        it.light_z     = $urandom;
        it.light_range = 31'($urandom);
      end
      default: begin
        it.light_x     = 32'(signed'($urandom_range(0, 200 << 16)) - (100 << 16));
        it.light_y     = 32'(signed'($urandom_range(0, 200 << 16)) - (100 << 16));
        it.light_z     = 32'(signed'($urandom_range(0, 200 << 16)) - (100 << 16));
        it.light_range = 31'($urandom_range(0, 1 << 22));
      end
    endcase
    return it;
  endfunction

  // Directed stimulus table; expected rect given where obvious, else predicted.
  typedef struct {
    light_t it;
    bit     has_exp;
    rect_t  exp;
  } dir_row_t;

  localparam rect_t FullScreen = '{rect_min_x: '0, rect_min_y: '0, rect_max_x: ScrOne,
                                   rect_max_y: ScrOne, behind_eye: 1'b1};

  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] mat [16];
    dir_row_t    dir_tab [$];
    rect_t       got;
    n_fail = 0;
    n_lights = 0;
    n_rects = 0;
    n_behind = 0;
    n_cfg = 0;
    sink_quiet = 1'b0;
    src_quiet = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i = RegM00M01;
    cfg_data_i = '0;
    for (int i = 0; i < CfgRegCount; i++) vp_copy[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the matrix is zero: w = 0 on every corner, so full screen.
    dir_tab.push_back('{'{32'sh0, 32'sh0, 32'sh0, 31'h0}, 1'b1, FullScreen});
    dir_tab.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF},
                       1'b1, FullScreen});
    foreach (dir_tab[i]) begin
      send_light(dir_tab[i].it);
      if (dir_tab[i].has_exp) rect_queue[$] = dir_tab[i].exp;
    end
    wait_idle();

    // Simple projection: x,y pass through, w = z (light in front when z > 0).
    mat = '{default: '0};
    mat[0]  = q16(1);
    mat[5]  = q16(1);
    mat[10] = q16(1);
    mat[14] = q16(1);
    load_matrix(mat);
    dir_tab.delete();
    // Centred light in front: symmetric rect around the middle.
    dir_tab.push_back('{'{32'sh0, 32'sh0, q16(10), 31'h1_0000}, 1'b0, FullScreen});
    // Light behind the eye.
    dir_tab.push_back('{'{32'sh0, 32'sh0, -q16(10), 31'h1_0000}, 1'b1, FullScreen});
    // Range reaching through the eye plane.
    dir_tab.push_back('{'{32'sh0, 32'sh0, q16(2), 31'h4_0000}, 1'b1, FullScreen});
    // Light entirely off to the right and top: min = max = one.
    dir_tab.push_back('{'{q16(1000), q16(1000), q16(1), 31'h1}, 1'b1,
                       '{ScrOne, ScrOne, ScrOne, ScrOne, 1'b0}});
    // Entirely off to the left and bottom.
    dir_tab.push_back('{'{-q16(1000), -q16(1000), q16(1), 31'h1}, 1'b1,
                       '{17'd0, 17'd0, 17'd0, 17'd0, 1'b0}});
    // Zero range, a negative x coordinate to exercise floor rounding.
    dir_tab.push_back('{'{-32'sd12345, 32'sd54321, q16(3), 31'h0}, 1'b0, FullScreen});
    // Saturating corners on each axis.
    dir_tab.push_back('{'{32'sh7FFF_0000, 32'sh8000_1000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF},
                       1'b0, FullScreen});
    dir_tab.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7000_0000, 31'h0100_0000},
                       1'b0, FullScreen});
    foreach (dir_tab[i]) begin
      send_light(dir_tab[i].it);
      if (dir_tab[i].has_exp) rect_queue[$] = dir_tab[i].exp;
    end
    wait_idle();

    // Random phases; each loads a new matrix while the block is idle.
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 16; i++) begin
        case (ph)
          0: mat[i] = 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
          1: mat[i] = $urandom;                      // extremes and noise
          2: mat[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: mat[i] = 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
        endcase
      end
      // Keep w mostly positive on well-behaved phases.
      if (ph != 1 && ph != 2) begin
        mat[12] = '0;
        mat[13] = '0;
        mat[14] = q16(1);
        mat[15] = q16(50);
      end
      load_matrix(mat);
      if (ph == 5) begin
        sink_quiet = 1'b1;
        src_quiet = 1'b1;
      end
      for (int n = 0; n < 180; n++) begin
        send_light(rand_light(($urandom_range(0, 9) < 7) ? 0 :
                              ($urandom_range(0, 1) ? 1 : 2)));
        // Pause the source until every rect is back, once per phase.
        if (n == 90) begin
          push <= 1'b0;
          while (rect_queue.size() != 0) @(posedge clk_i);
        end
      end
      wait_idle();
    end

    $display("covered %0d lights, %0d rects (%0d behind eye), %0d register writes",
             n_lights, n_rects, n_behind, n_cfg);
    if (n_fail == 0) begin
      $display("light_sphere_screen_rect: match");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("light_sphere_screen_rect: mismatch");
    end
    $finish;
  end

endmodule
